// ----- rtl/rbt_pkg.sv -----
package rbt_pkg;

  // field widths
  localparam int SIZE_W   = 24;
  localparam int CNT_W    = 16;
  localparam int ENTRY_W  = SIZE_W + CNT_W;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 3;
  localparam int IDX_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int USEDO_W  = 30;
  localparam int AVAIL_W  = 31;

  localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [USEDO_W-1:0] USED_MAX  = '1;

  // action codes
  localparam logic [ACT_W-1:0] ACT_CREATE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RESIZE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_MEM    = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;

  // register byte addresses (bit 2 selects the register slot)
  localparam logic REG_MEM_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC,
    S_SHIFT_RD,
    S_SHIFT
  } rbt_state_t;

  typedef struct packed {
    logic load;
    logic rd_req;
    logic exec;
    logic shift_rd;
    logic shift_wr;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic do_shift;
    logic shift_done;
  } dp_stat_t;

endpackage

// ----- rtl/rbt_ram.sv -----
module rbt_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rbt_ctrl.sv -----
module rbt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rbt_pkg::dp_stat_t stat,
  output rbt_pkg::ctl_cmd_t cmd,
  output logic              idle
);
  import rbt_pkg::*;

  rbt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    idle       = 1'b0;
    unique case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.rd_req = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // keep the read address steady while the result register is full
        cmd.rd_req = 1'b1;
        if (!stat.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = stat.do_shift ? S_SHIFT_RD : S_IDLE;
        end
      end
      S_SHIFT_RD: begin
        cmd.shift_rd = 1'b1;
        state_next   = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift_wr = 1'b1;
        if (stat.shift_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/rbt_dpath.sv -----
module rbt_dpath #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rbt_pkg::ctl_cmd_t                      cmd,
  output rbt_pkg::dp_stat_t                      stat,
  input  logic [rbt_pkg::ACT_W-1:0]              in_action,
  input  logic [rbt_pkg::IDX_W-1:0]              in_block_index,
  input  logic [rbt_pkg::SIZE_W-1:0]             in_block_size,
  input  logic [rbt_pkg::SIZE_W-1:0]             mem_limit,
  output logic                                   ram_we,
  output logic [$clog2(MAX_BLOCKS)-1:0]          ram_waddr,
  output logic [rbt_pkg::ENTRY_W-1:0]            ram_wdata,
  output logic [$clog2(MAX_BLOCKS)-1:0]          ram_raddr,
  input  logic [rbt_pkg::ENTRY_W-1:0]            ram_rdata,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic [rbt_pkg::STAT_W-1:0]             status,
  output logic [rbt_pkg::IDX_W-1:0]              new_index,
  output logic [rbt_pkg::COUNT_W-1:0]            block_count,
  output logic [rbt_pkg::USEDO_W-1:0]            used_words,
  output logic signed [rbt_pkg::AVAIL_W-1:0]     available_memory,
  output logic [rbt_pkg::CNT_W-1:0]              ref_count,
  output logic                                   freed
);
  import rbt_pkg::*;

  localparam int AW     = $clog2(MAX_BLOCKS);
  localparam int LIVE_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDXW   = (LIVE_W > IDX_W) ? LIVE_W : IDX_W;
  localparam int USED_W = SIZE_W + AW;
  localparam int EXT_W  = (USED_W > USEDO_W) ? USED_W : USEDO_W;

  logic [ACT_W-1:0]  req_action;
  logic [IDX_W-1:0]  req_idx;
  logic [SIZE_W-1:0] req_size;
  logic [LIVE_W-1:0] live;
  logic [USED_W-1:0] used;
  logic [AW-1:0]     ptr;

  logic [IDXW-1:0]   idx_w;
  logic              idx_ok;
  logic [AW-1:0]     idx_addr;
  logic [SIZE_W-1:0] old_size;
  logic [CNT_W-1:0]  old_cnt;

  logic [EXT_W-1:0]          used_ext, used_n_ext;
  logic [USEDO_W-1:0]        sat_cur, sat_n;
  logic signed [AVAIL_W-1:0] avail_cur, avail_n;

  logic [STAT_W-1:0]  st;
  logic [IDX_W-1:0]   nidx;
  logic [CNT_W-1:0]   refc;
  logic               free;
  logic               wr;
  logic [AW-1:0]      waddr_e;
  logic [ENTRY_W-1:0] wdata_e;
  logic [LIVE_W-1:0]  live_n;
  logic [USED_W-1:0]  used_n;

  assign idx_w    = IDXW'(req_idx);
  assign idx_ok   = idx_w < IDXW'(live);
  assign idx_addr = idx_w[AW-1:0];
  assign old_size = ram_rdata[ENTRY_W-1:CNT_W];
  assign old_cnt  = ram_rdata[CNT_W-1:0];

  // usage before the action, saturated to the reported width
  assign used_ext  = EXT_W'(used);
  assign sat_cur   = (used_ext > EXT_W'(USED_MAX)) ? USED_MAX : used_ext[USEDO_W-1:0];
  assign avail_cur = $signed({{(AVAIL_W-SIZE_W){1'b0}}, mem_limit})
                   - $signed({1'b0, sat_cur});

  always_comb begin
    st      = ST_OK;
    nidx    = '0;
    refc    = '0;
    free    = 1'b0;
    wr      = 1'b0;
    waddr_e = idx_addr;
    wdata_e = {req_size, old_cnt};
    live_n  = live;
    used_n  = used;
    unique case (req_action)
      ACT_CREATE: begin
        if (req_size == '0) begin
          st = ST_BAD_SIZE;
        end else if (live >= LIVE_W'(MAX_BLOCKS) ||
                     $signed({{(AVAIL_W-SIZE_W){1'b0}}, req_size}) > avail_cur) begin
          st = ST_NO_MEM;
        end else begin
          wr      = 1'b1;
          waddr_e = live[AW-1:0];
          wdata_e = {req_size, CNT_W'(1)};
          nidx    = IDX_W'(live);
          refc    = CNT_W'(1);
          live_n  = live + LIVE_W'(1);
          used_n  = used + USED_W'(req_size);
        end
      end
      ACT_RESIZE: begin
        if (!idx_ok) begin
          st = ST_BAD_INDEX;
        end else if (req_size == '0) begin
          st = ST_BAD_SIZE;
        end else begin
          wr      = 1'b1;
          wdata_e = {req_size, old_cnt};
          refc    = old_cnt;
          used_n  = used - USED_W'(old_size) + USED_W'(req_size);
        end
      end
      ACT_ADD: begin
        if (!idx_ok) begin
          st = ST_BAD_INDEX;
        end else if (old_cnt == COUNT_MAX) begin
          st   = ST_OVERFLOW;
          refc = COUNT_MAX;
        end else begin
          wr      = 1'b1;
          wdata_e = {old_size, old_cnt + CNT_W'(1)};
          refc    = old_cnt + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (!idx_ok) begin
          st = ST_BAD_INDEX;
        end else if (old_cnt <= CNT_W'(1)) begin
          // last reference: drop the block and close the gap
          free   = 1'b1;
          live_n = live - LIVE_W'(1);
          used_n = used - USED_W'(old_size);
        end else begin
          wr      = 1'b1;
          wdata_e = {old_size, old_cnt - CNT_W'(1)};
          refc    = old_cnt - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign used_n_ext = EXT_W'(used_n);
  assign sat_n      = (used_n_ext > EXT_W'(USED_MAX)) ? USED_MAX : used_n_ext[USEDO_W-1:0];
  assign avail_n    = $signed({{(AVAIL_W-SIZE_W){1'b0}}, mem_limit})
                    - $signed({1'b0, sat_n});

  assign stat.out_busy   = out_valid && out_stall;
  assign stat.do_shift   = free && (idx_w + IDXW'(1) != IDXW'(live));
  assign stat.shift_done = (LIVE_W'(ptr) + LIVE_W'(1)) == live;

  // table port
  always_comb begin
    if (cmd.rd_req) begin
      ram_raddr = idx_addr;
    end else if (cmd.shift_rd) begin
      ram_raddr = ptr + AW'(1);
    end else begin
      ram_raddr = ptr + AW'(2);
    end
  end

  assign ram_we    = (cmd.exec && wr) || cmd.shift_wr;
  assign ram_waddr = cmd.shift_wr ? ptr : waddr_e;
  assign ram_wdata = cmd.shift_wr ? ram_rdata : wdata_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      live      <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        live      <= live_n;
        used      <= used_n;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action <= in_action;
      req_idx    <= in_block_index;
      req_size   <= in_block_size;
    end
    if (cmd.exec) begin
      ptr              <= idx_addr;
      status           <= st;
      new_index        <= nidx;
      block_count      <= COUNT_W'(live_n);
      used_words       <= sat_n;
      available_memory <= avail_n;
      ref_count        <= refc;
      freed            <= free;
    end else if (cmd.shift_wr) begin
      ptr <= ptr + AW'(1);
    end
  end

endmodule

// ----- rtl/refcount_block_table.sv -----
// refcount_block_table: packed table of reference counted blocks under a word budget
//
// requests enter on the input channel (in_valid / in_stall): an action,
// a block index and a block size. every request yields exactly one result
// on the output channel (out_valid / out_stall) carrying status, the new
// index of a created block, live block count, used and available memory,
// the reference count of the addressed block and a freed flag.
//
// one request is worked at a time. a request is taken in idle, the table
// entry is read in the lookup state, and the result is registered in the
// exec state, which waits while the output register is full; the next
// request is taken once the sequencer is back in idle. a remove that
// frees a block that is not the last also walks the later entries down
// one slot, one table write per cycle.
//
// the result sits in an output register; while out_stall holds it, the
// next request is still taken and looked up, and waits only for its own
// commit. mem_limit is written over the APB port at byte address 0.
// reset clears the live count, used total, budget and output valid; table
// contents are not cleared, only entries below the live count are used.
module refcount_block_table #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rbt_pkg::ACT_W-1:0]           action,
  input  logic [rbt_pkg::IDX_W-1:0]           block_index,
  input  logic [rbt_pkg::SIZE_W-1:0]          block_size,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rbt_pkg::STAT_W-1:0]          status,
  output logic [rbt_pkg::IDX_W-1:0]           new_index,
  output logic [rbt_pkg::COUNT_W-1:0]         block_count,
  output logic [rbt_pkg::USEDO_W-1:0]         used_words,
  output logic signed [rbt_pkg::AVAIL_W-1:0]  available_memory,
  output logic [rbt_pkg::CNT_W-1:0]           ref_count,
  output logic                                freed,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import rbt_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);

  ctl_cmd_t          cmd;
  dp_stat_t          stat;
  logic              idle;
  logic [SIZE_W-1:0] mem_limit;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // apb register file: paddr bit 2 picks the register slot
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_limit <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MEM_LIMIT) begin
      mem_limit <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MEM_LIMIT) ? {{(32-SIZE_W){1'b0}}, mem_limit} : '0;

  // requests are only taken while the sequencer is idle
  assign in_stall = !idle;

  rbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle)
  );

  rbt_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_action        (action),
    .in_block_index   (block_index),
    .in_block_size    (block_size),
    .mem_limit        (mem_limit),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .status           (status),
    .new_index        (new_index),
    .block_count      (block_count),
    .used_words       (used_words),
    .available_memory (available_memory),
    .ref_count        (ref_count),
    .freed            (freed)
  );

  // size and count of each live block, packed {size, count}
  rbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- rtl/rbt_checker.sv -----
module rbt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [rbt_pkg::STAT_W-1:0]          status,
  input logic [rbt_pkg::IDX_W-1:0]           new_index,
  input logic [rbt_pkg::USEDO_W-1:0]         used_words,
  input logic signed [rbt_pkg::AVAIL_W-1:0]  available_memory,
  input logic [rbt_pkg::CNT_W-1:0]           ref_count,
  input logic                                freed,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic                                pready,
  input logic [2:0]                          paddr,
  input logic [31:0]                         pwdata
);
  import rbt_pkg::*;

  logic [SIZE_W-1:0] limit_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_seen <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MEM_LIMIT) begin
      limit_seen <= pwdata[SIZE_W-1:0];
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(used_words))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  a_freed: assert property (@(posedge clk) disable iff (rst)
    out_valid && freed |-> status == ST_OK && ref_count == '0)
    else $error("freed result carries a count or an error");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !freed && new_index == '0)
    else $error("failed request reports a side effect");

  a_avail: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> available_memory ==
      $signed({{(AVAIL_W-SIZE_W){1'b0}}, limit_seen}) - $signed({1'b0, used_words}))
    else $error("available memory does not match budget and usage");

endmodule

bind refcount_block_table rbt_checker u_rbt_checker (.*);

// ----- tb/sv/refcount_block_table_tb.sv -----
module refcount_block_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbt_pkg::*;

  localparam int MAX_BLOCKS = 64;

  // action codes with no package name: query and the spare codes that act as query
  localparam logic [ACT_W-1:0] ACT_QUERY    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  // register byte address of the budget
  localparam logic [2:0] ADDR_MEM_LIMIT = 3'd0;

  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
  localparam int IDX_MAX = (1 << IDX_W) - 1;

  // slowest legal gap between two handshakes is the long receiver hold
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = MAX_BLOCKS + 4;
  localparam int LOOKAHEAD      = 4;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  index;
    logic [SIZE_W-1:0] size;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   new_index;
    logic [COUNT_W-1:0] block_count;
    logic [USEDO_W-1:0] used;
    logic [AVAIL_W-1:0] avail;
    logic [CNT_W-1:0]   refs;
    logic               freed;
  } outcome_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // request channel
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [ACT_W-1:0]    action      = '0;
  logic [IDX_W-1:0]    block_index = '0;
  logic [SIZE_W-1:0]   block_size  = '0;

  // result channel
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [STAT_W-1:0]         status;
  logic [IDX_W-1:0]          new_index;
  logic [COUNT_W-1:0]        block_count;
  logic [USEDO_W-1:0]        used_words;
  logic signed [AVAIL_W-1:0] available_memory;
  logic [CNT_W-1:0]          ref_count;
  logic                      freed;

  // configuration port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  refcount_block_table #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .action           (action),
    .block_index      (block_index),
    .block_size       (block_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .new_index        (new_index),
    .block_count      (block_count),
    .used_words       (used_words),
    .available_memory (available_memory),
    .ref_count        (ref_count),
    .freed            (freed),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // shadow of the block table, advanced once per accepted request
  logic [SIZE_W-1:0] shadow_size [MAX_BLOCKS];
  logic [CNT_W-1:0]  shadow_refs [MAX_BLOCKS];
  int                live_n   = 0;
  longint            used_sum = 0;
  logic [SIZE_W-1:0] budget   = '0;

  request_t request_q [$];   // requests waiting for the driver
  outcome_t outcome_q [$];   // predicted results, oldest first
  request_t on_bus;          // request currently offered to the block

  int  fail_count  = 0;
  int  idle_cycles = 0;
  int  send_gap    = 0;
  int  send_calm   = 0;
  int  stall_left  = 0;
  int  stall_calm  = 0;
  int  hold_left   = 0;
  bit  hold_req    = 1'b0;
  bit  quiet       = 1'b0;

  // used total as reported, clipped to the output width
  function automatic longint used_clipped();
    return (used_sum > longint'(USED_MAX)) ? longint'(USED_MAX) : used_sum;
  endfunction

  // signed room left under the budget
  function automatic longint headroom();
    return longint'(budget) - used_clipped();
  endfunction

  // applies one request to the shadow table and returns the result it must produce
  function automatic outcome_t predict_outcome(request_t r);
    outcome_t o;
    longint   room;
    longint   shown;
    int       slot;
    int       c;
    int       k;
    bit       idx_ok;
    o      = '0;
    slot   = int'(r.index);
    idx_ok = slot < live_n;
    case (r.action)
      ACT_CREATE: begin
        if (r.size == '0) begin
          o.status = ST_BAD_SIZE;
        end else if (live_n >= MAX_BLOCKS || longint'(r.size) > headroom()) begin
          o.status = ST_NO_MEM;
        end else begin
          shadow_size[live_n] = r.size;
          shadow_refs[live_n] = 1;
          o.new_index = IDX_W'(live_n);
          o.refs      = 1;
          live_n++;
          used_sum += longint'(r.size);
        end
      end
      ACT_RESIZE: begin
        if (!idx_ok) begin
          o.status = ST_BAD_INDEX;
        end else if (r.size == '0) begin
          o.status = ST_BAD_SIZE;
        end else begin
          used_sum = used_sum - longint'(shadow_size[slot]) + longint'(r.size);
          shadow_size[slot] = r.size;
          o.refs = shadow_refs[slot];
        end
      end
      ACT_ADD: begin
        if (!idx_ok) begin
          o.status = ST_BAD_INDEX;
        end else if (shadow_refs[slot] == COUNT_MAX) begin
          // count saturates and reports the overflow
          o.status = ST_OVERFLOW;
          o.refs   = COUNT_MAX;
        end else begin
          shadow_refs[slot] = shadow_refs[slot] + CNT_W'(1);
          o.refs = shadow_refs[slot];
        end
      end
      ACT_REMOVE: begin
        if (!idx_ok) begin
          o.status = ST_BAD_INDEX;
        end else begin
          c = int'(shadow_refs[slot]);
          c = (c == 0) ? 0 : c - 1;
          if (c == 0) begin
            // last reference gone: free and close the gap
            used_sum -= longint'(shadow_size[slot]);
            for (k = slot; k + 1 < live_n; k++) begin
              shadow_size[k] = shadow_size[k + 1];
              shadow_refs[k] = shadow_refs[k + 1];
            end
            live_n--;
            o.freed = 1'b1;
          end else begin
            shadow_refs[slot] = CNT_W'(c);
            o.refs = CNT_W'(c);
          end
        end
      end
      default: begin
      end
    endcase
    room  = headroom();
    shown = used_clipped();
    o.block_count = COUNT_W'(live_n);
    o.used        = shown[USEDO_W-1:0];
    o.avail       = room[AVAIL_W-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, outcome_t want, outcome_t seen);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: exp st=%0d ni=%0d cnt=%0d used=%0d avail=%0d refs=%0d freed=%0d",
               $time, what, want.status, want.new_index, want.block_count, want.used,
               $signed(want.avail), want.refs, want.freed);
      $display("%0t %s: got st=%0d ni=%0d cnt=%0d used=%0d avail=%0d refs=%0d freed=%0d",
               $time, what, seen.status, seen.new_index, seen.block_count, seen.used,
               $signed(seen.avail), seen.refs, seen.freed);
    end
  endtask

  // driver: predicts on acceptance, then offers the next request or idles
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap  = 0;
    end else begin
      if (in_valid && !in_stall) begin
        outcome_q.push_back(predict_outcome(on_bus));
      end
      // a stalled request holds its payload
      if (!in_valid || !in_stall) begin
        if (send_calm > 0) begin
          send_calm--;
        end else if (!quiet && $urandom_range(0, 63) == 0) begin
          send_calm = $urandom_range(20, 80);
        end
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet && send_calm == 0 && $urandom_range(0, 5) == 0) begin
          // start a random burst of idle cycles, this one included
          send_gap = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else begin
          on_bus = request_q.pop_front();
          in_valid    <= 1'b1;
          action      <= on_bus.action;
          block_index <= on_bus.index;
          block_size  <= on_bus.size;
        end
      end
    end
  end

  // monitor: checks each accepted result against the oldest prediction, drives stall
  always @(posedge clk) begin
    outcome_t seen;
    outcome_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {status, new_index, block_count, used_words, available_memory,
                ref_count, freed};
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no request pending", '0, seen);
        end else begin
          want = outcome_q.pop_front();
          if (seen !== want) begin
            report_mismatch("result mismatch", want, seen);
          end
        end
      end
      // long hold-off asked for by the stimulus, counted here
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (stall_calm > 0) begin
        stall_calm--;
      end else if (!quiet && $urandom_range(0, 63) == 0) begin
        stall_calm = $urandom_range(20, 80);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && stall_calm == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: too long with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // queue one request, staying at most LOOKAHEAD requests ahead of the driver
  task automatic send(logic [ACT_W-1:0] act, int idx, logic [SIZE_W-1:0] sz);
    request_t r;
    @(negedge clk);
    while (request_q.size() >= LOOKAHEAD) @(negedge clk);
    r.action = act;
    r.index  = IDX_W'(idx);
    r.size   = sz;
    request_q.push_back(r);
  endtask

  // sender pause until every predicted result has come back and the block is idle
  task automatic wait_idle();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || outcome_q.size() != 0 || in_stall);
    repeat (4) @(negedge clk);
  endtask

  // budget write, then read back
  task automatic set_budget(logic [SIZE_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MEM_LIMIT;
    pwdata  <= {8'h00, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    budget = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== {8'h00, value}) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t budget readback: exp %0d got %0d", $time, value, prdata);
      end
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random traffic; most indices hit live blocks, sizes mostly up to size_cap
  task automatic random_run(int n, int create_w, int size_cap);
    int               i;
    int               roll;
    int               idx;
    logic [ACT_W-1:0] act;
    logic [SIZE_W-1:0] sz;
    for (i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < create_w) act = ACT_CREATE;
      else if (roll < create_w + 12) act = ACT_RESIZE;
      else if (roll < create_w + 30) act = ACT_ADD;
      else if (roll < 94) act = ACT_REMOVE;
      else if (roll < 97) act = ACT_QUERY;
      else act = ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
      if (live_n > 0 && $urandom_range(0, 99) < 85) idx = $urandom_range(0, live_n - 1);
      else idx = $urandom_range(0, IDX_MAX);
      roll = $urandom_range(0, 99);
      if (act != ACT_CREATE && act != ACT_RESIZE) sz = SIZE_W'($urandom);
      else if (roll < 5) sz = '0;
      else if (roll < 15) sz = SIZE_W'($urandom);
      else sz = SIZE_W'($urandom_range(1, size_cap));
      send(act, idx, sz);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // budget at reset is zero: create must fail
    send(ACT_CREATE, 0, 5);
    send(ACT_QUERY, 0, 0);
    wait_idle();
    set_budget(100);

    // size checks, fill the budget, bad indices, resize past the budget
    send(ACT_CREATE, 0, 0);
    send(ACT_CREATE, 0, 40);
    send(ACT_CREATE, 0, 60);
    send(ACT_CREATE, 0, 1);
    send(ACT_RESIZE, 5, 7);
    send(ACT_RESIZE, 0, 0);
    send(ACT_RESIZE, 0, SIZE_MAX);
    send(ACT_ADD, 1, 0);
    send(ACT_ADD, IDX_MAX, 0);
    // decrement, then two frees, the first with compaction, then remove on an empty table
    send(ACT_REMOVE, 1, 0);
    send(ACT_REMOVE, 0, 0);
    send(ACT_REMOVE, 0, 0);
    send(ACT_REMOVE, 0, 0);
    // spare action codes behave as query
    send(ACT_SPARE_HI, IDX_MAX, SIZE_MAX);
    send(ACT_SPARE_LO, 0, 0);
    send(ACT_CREATE, 0, SIZE_MAX);
    send(ACT_SPARE_LO + ACT_W'(1), 0, 0);
    wait_idle();

    // full budget, create heavy: table fills up and rejects
    set_budget(SIZE_MAX);
    random_run(250, 45, 4096);
    wait_idle();

    // tight budget, long receiver hold in the middle
    set_budget(5000);
    random_run(100, 35, 300);
    @(negedge clk);
    hold_req = 1'b1;
    random_run(100, 35, 300);
    wait_idle();

    set_budget(SIZE_W'($urandom_range(1, SIZE_MAX)));
    random_run(250, 30, 65536);
    wait_idle();

    // zero budget: every create fails; removal, resize and add still make progress
    set_budget('0);
    random_run(80, 30, 64);
    wait_idle();

    // smallest nonzero budget
    set_budget(1);
    random_run(120, 35, 2);
    wait_idle();

    // last stretch without idling on either side
    set_budget(SIZE_MAX);
    quiet = 1'b1;
    random_run(250, 40, 4096);
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
